FILE: design/assert_macros.svh
// assertion macros shared by the crop router rtl
// no dependencies; expects signals named clock and reset in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define FWCR_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FWCR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/fwcr_pkg.sv
// types, constants and register codes of the five window crop router
// no dependencies; used by every module of the block
`default_nettype none

package fwcr_pkg;

   localparam int MAX_DIM           = 4096;
   localparam int MAX_CROPS_DEFAULT = 5;
   localparam int PIXEL_BITS        = 32;

   localparam int DIM_BITS   = $clog2(MAX_DIM);   // row and column counters
   localparam int IMG_BITS   = 13;
   localparam int CROP_BITS  = 12;
   localparam int COUNT_BITS = 3;
   localparam int CODES_BITS = 15;
   localparam int CODE_BITS  = 3;
   localparam int CODE_SLOTS = 5;
   localparam int IDX_BITS   = 3;
   localparam int CSR_BITS   = 15;
   localparam int ADDR_BITS  = 3;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [ADDR_BITS-1:0] {
      REG_IMAGE_HEIGHT   = 3'd0,
      REG_IMAGE_WIDTH    = 3'd1,
      REG_CROP_HEIGHT    = 3'd2,
      REG_CROP_WIDTH     = 3'd3,
      REG_CROP_COUNT     = 3'd4,
      REG_POSITION_CODES = 3'd5
   } csr_reg_type;

   typedef enum logic [CODE_BITS-1:0] {
      POS_CENTER      = 3'd0,
      POS_UPPER_LEFT  = 3'd1,
      POS_UPPER_RIGHT = 3'd2,
      POS_LOWER_LEFT  = 3'd3,
      POS_LOWER_RIGHT = 3'd4
   } pos_code_type;

   localparam logic [IMG_BITS-1:0]   RESET_IMAGE_HEIGHT   = 13'd256;
   localparam logic [IMG_BITS-1:0]   RESET_IMAGE_WIDTH    = 13'd256;
   localparam logic [CROP_BITS-1:0]  RESET_CROP_HEIGHT    = 12'd224;
   localparam logic [CROP_BITS-1:0]  RESET_CROP_WIDTH     = 12'd224;
   localparam logic [COUNT_BITS-1:0] RESET_CROP_COUNT     = 3'd5;
   localparam logic [CODES_BITS-1:0] RESET_POSITION_CODES = 15'd18056;

   typedef struct packed {
      logic [IMG_BITS-1:0]   image_height;
      logic [IMG_BITS-1:0]   image_width;
      logic [CROP_BITS-1:0]  crop_height;
      logic [CROP_BITS-1:0]  crop_width;
      logic [COUNT_BITS-1:0] crop_count;
      logic [CODES_BITS-1:0] position_codes;
   } cfg_type;

   // one classified pixel: which windows take it and where
   typedef struct packed {
      logic [PIXEL_BITS-1:0]                pixel;
      logic [CODE_SLOTS-1:0]                mask;
      logic [CODE_SLOTS-1:0][CROP_BITS-1:0] row;
      logic [CODE_SLOTS-1:0][CROP_BITS-1:0] col;
   } item_type;

   // image size forced into 1 .. MAX_DIM
   function automatic logic [IMG_BITS-1:0] clamp_dim(input logic [IMG_BITS-1:0] v);
      logic [IMG_BITS-1:0] r;
      r = v;
      if (v == '0) begin
         r = IMG_BITS'(1);
      end else if (v > IMG_BITS'(MAX_DIM)) begin
         r = IMG_BITS'(MAX_DIM);
      end
      return r;
   endfunction

   // half of the size difference, zero when the crop does not fit
   function automatic logic [DIM_BITS-1:0] half_gap(input logic [IMG_BITS-1:0]  img,
                                                    input logic [CROP_BITS-1:0] crop);
      logic [IMG_BITS-1:0] diff;
      diff = img - {{(IMG_BITS-CROP_BITS){1'b0}}, crop};
      if ({{(IMG_BITS-CROP_BITS){1'b0}}, crop} >= img) begin
         diff = '0;
      end
      return DIM_BITS'(diff >> 1);
   endfunction

endpackage

`default_nettype wire

FILE: design/five_window_crop_router.sv
// five window crop router top level: config registers, front end, queue, back end
// path: input register, queue entry, back end work register, response register
// throughput: one request per cycle while each pixel falls in at most one window and
//   the response side does not stall; a pixel inside n windows (up to 5) gives n
//   responses, one per cycle on the single response port while it is ready, the queue absorbs bursts
// reset: synchronous, restores register defaults, zeroes counters, empties queue
`default_nettype none
`include "assert_macros.svh"

module five_window_crop_router #(
   parameter int MAX_CROPS = fwcr_pkg::MAX_CROPS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // config write port
   input  wire logic                           csr_we,
   input  wire logic [fwcr_pkg::ADDR_BITS-1:0] csr_addr,
   input  wire logic [fwcr_pkg::CSR_BITS-1:0]  csr_wdata,
   // request stream
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [31:0]                    req_tdata,  // [31:0] pixel_value
   input  wire logic                           req_tuser,  // [0] plane_start
   // response stream
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [55:0]                         rsp_tdata,  // [11:0] crop_row,
                                                           // [23:12] crop_col,
                                                           // [55:24] pixel_out
   output logic [2:0]                          rsp_tuser,  // [2:0] crop_index
   output logic                                rsp_tlast   // last_of_run
);

   // config registers
   fwcr_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (fwcr_pkg::csr_reg_type'(csr_addr))
            fwcr_pkg::REG_IMAGE_HEIGHT:
               cfg_in.image_height = fwcr_pkg::IMG_BITS'(csr_wdata);
            fwcr_pkg::REG_IMAGE_WIDTH:
               cfg_in.image_width = fwcr_pkg::IMG_BITS'(csr_wdata);
            fwcr_pkg::REG_CROP_HEIGHT:
               cfg_in.crop_height = fwcr_pkg::CROP_BITS'(csr_wdata);
            fwcr_pkg::REG_CROP_WIDTH:
               cfg_in.crop_width = fwcr_pkg::CROP_BITS'(csr_wdata);
            fwcr_pkg::REG_CROP_COUNT:
               cfg_in.crop_count = fwcr_pkg::COUNT_BITS'(csr_wdata);
            fwcr_pkg::REG_POSITION_CODES:
               cfg_in.position_codes = csr_wdata;
            default: begin
               // unknown index, write dropped
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_height   <= fwcr_pkg::RESET_IMAGE_HEIGHT;
         cfg_ff.image_width    <= fwcr_pkg::RESET_IMAGE_WIDTH;
         cfg_ff.crop_height    <= fwcr_pkg::RESET_CROP_HEIGHT;
         cfg_ff.crop_width     <= fwcr_pkg::RESET_CROP_WIDTH;
         cfg_ff.crop_count     <= fwcr_pkg::RESET_CROP_COUNT;
         cfg_ff.position_codes <= fwcr_pkg::RESET_POSITION_CODES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end -> queue -> back end
   logic               q_push, q_full, q_valid, q_pop;
   fwcr_pkg::item_type q_push_item, q_head;

   fwcr_front #(
      .MAX_CROPS (MAX_CROPS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_pixel (req_tdata[fwcr_pkg::PIXEL_BITS-1:0]),
      .req_start (req_tuser),
      .q_push    (q_push),
      .q_item    (q_push_item),
      .q_full    (q_full)
   );

   fwcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   logic [fwcr_pkg::CROP_BITS-1:0]  crop_row, crop_col;
   logic [fwcr_pkg::PIXEL_BITS-1:0] pixel_out;

   fwcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_index (rsp_tuser),
      .rsp_row   (crop_row),
      .rsp_col   (crop_col),
      .rsp_pixel (pixel_out),
      .rsp_last  (rsp_tlast)
   );

   // pack response payload, row in the low bits
   assign rsp_tdata = {pixel_out, crop_col, crop_row};

   // front end only pushes when the queue has room
   `FWCR_ASSERT_ALWAYS(a_queue_no_overflow, !(q_push && q_full), "queue overflow")
   // every queued pixel has at least one window to serve
   `FWCR_ASSERT_ALWAYS(a_queue_head_nonempty, !q_valid || (q_head.mask != '0), "empty mask queued")
   // window index on the response is always a real window
   `FWCR_ASSERT_ALWAYS(a_rsp_index_range,
      !rsp_tvalid || (rsp_tuser < fwcr_pkg::IDX_BITS'(fwcr_pkg::CODE_SLOTS)), "bad crop index")
   // a pop always follows from a non-empty queue and leaves the next head or empty
   `FWCR_ASSERT_NEXT(a_pop_needs_data, q_pop, $past(q_valid), "pop from empty queue")

endmodule

`default_nettype wire

FILE: design/fwcr_front.sv
// front end: request register, row/column counters and window classification
// depends on fwcr_pkg
`default_nettype none

module fwcr_front #(
   parameter int MAX_CROPS = fwcr_pkg::MAX_CROPS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire fwcr_pkg::cfg_type               cfg,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [fwcr_pkg::PIXEL_BITS-1:0] req_pixel,
   input  wire logic                            req_start,
   output logic                                 q_push,
   output fwcr_pkg::item_type                   q_item,
   input  wire logic                            q_full
);

   localparam int USED_MAX = (MAX_CROPS < fwcr_pkg::CODE_SLOTS) ?
                             MAX_CROPS : fwcr_pkg::CODE_SLOTS;
   localparam int DB = fwcr_pkg::DIM_BITS;

   // geometry derived from the registers, taking their values in the cycle after they change
   logic [fwcr_pkg::IMG_BITS-1:0]                       h_img_ff, w_img_ff;
   logic [DB-1:0]                                       h_off_ff, w_off_ff;
   logic [fwcr_pkg::CODE_SLOTS-1:0]                     lane_en_ff;
   logic [fwcr_pkg::CODE_SLOTS-1:0][fwcr_pkg::CODE_BITS-1:0] code_ff;
   logic [fwcr_pkg::CODE_SLOTS-1:0]                     lane_en_in;

   logic                            in_valid_ff, in_valid_in;
   logic [fwcr_pkg::PIXEL_BITS-1:0] in_pixel_ff;
   logic                            in_start_ff;
   logic [DB-1:0]                   row_ff, row_in, col_ff, col_in;

   logic                            advance;
   logic [DB-1:0]                   r, c;
   logic [fwcr_pkg::IMG_BITS-1:0]   c_next, r_next;
   logic [DB-1:0]                   y, x;
   logic [DB:0]                     dr, dc;

   always_comb begin
      lane_en_in = '0;
      for (int k = 0; k < fwcr_pkg::CODE_SLOTS; k++) begin
         lane_en_in[k] = (k < USED_MAX) &&
                         (fwcr_pkg::COUNT_BITS'(k) < cfg.crop_count) &&
                         (cfg.position_codes[k*fwcr_pkg::CODE_BITS +: fwcr_pkg::CODE_BITS]
                          < fwcr_pkg::CODE_BITS'(fwcr_pkg::CODE_SLOTS));
      end
   end

   always_ff @(posedge clock) begin
      h_img_ff   <= fwcr_pkg::clamp_dim(cfg.image_height);
      w_img_ff   <= fwcr_pkg::clamp_dim(cfg.image_width);
      h_off_ff   <= fwcr_pkg::half_gap(fwcr_pkg::clamp_dim(cfg.image_height), cfg.crop_height);
      w_off_ff   <= fwcr_pkg::half_gap(fwcr_pkg::clamp_dim(cfg.image_width), cfg.crop_width);
      lane_en_ff <= lane_en_in;
      code_ff    <= cfg.position_codes;
   end

   assign advance   = in_valid_ff && !q_full;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // position of the current pixel
   always_comb begin
      r = row_ff;
      c = col_ff;
      if (in_start_ff || ({1'b0, row_ff} >= h_img_ff)) begin
         r = '0;
      end
      if (in_start_ff || ({1'b0, col_ff} >= w_img_ff)) begin
         c = '0;
      end
      c_next = {1'b0, c} + 1'b1;
      r_next = {1'b0, r} + 1'b1;
      row_in = row_ff;
      col_in = col_ff;
      if (advance) begin
         if (c_next >= w_img_ff) begin
            col_in = '0;
            row_in = (r_next >= h_img_ff) ? '0 : DB'(r_next);
         end else begin
            col_in = DB'(c_next);
            row_in = r;
         end
      end
   end

   // per window hit test and coordinates
   always_comb begin
      q_item       = '0;
      q_item.pixel = in_pixel_ff;
      for (int k = 0; k < fwcr_pkg::CODE_SLOTS; k++) begin
         y = '0;
         x = '0;
         unique case (fwcr_pkg::pos_code_type'(code_ff[k]))
            fwcr_pkg::POS_CENTER: begin
               y = h_off_ff;
               x = w_off_ff;
            end
            fwcr_pkg::POS_UPPER_LEFT: begin
               y = '0;
               x = '0;
            end
            fwcr_pkg::POS_UPPER_RIGHT: begin
               y = '0;
               x = DB'({w_off_ff, 1'b0});
            end
            fwcr_pkg::POS_LOWER_LEFT: begin
               y = DB'({h_off_ff, 1'b0});
               x = '0;
            end
            fwcr_pkg::POS_LOWER_RIGHT: begin
               y = DB'({h_off_ff, 1'b0});
               x = DB'({w_off_ff, 1'b0});
            end
            default: begin
               y = '0;
               x = '0;
            end
         endcase
         dr = {1'b0, r} - {1'b0, y};
         dc = {1'b0, c} - {1'b0, x};
         q_item.row[k]  = fwcr_pkg::CROP_BITS'(dr);
         q_item.col[k]  = fwcr_pkg::CROP_BITS'(dc);
         q_item.mask[k] = lane_en_ff[k] && !dr[DB] && !dc[DB] &&
                          (fwcr_pkg::CROP_BITS'(dr) < cfg.crop_height) &&
                          (fwcr_pkg::CROP_BITS'(dc) < cfg.crop_width);
      end
   end

   // pixels that land in no window still move the counters
   assign q_push = advance && (q_item.mask != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         row_ff      <= '0;
         col_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_pixel_ff <= req_pixel;
         in_start_ff <= req_start;
      end
   end

endmodule

`default_nettype wire

FILE: design/fwcr_queue.sv
// small register queue between the front end and the back end
// depends on fwcr_pkg
`default_nettype none

module fwcr_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire fwcr_pkg::item_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output logic                    valid,
   output fwcr_pkg::item_type      head
);

   localparam int DEPTH     = fwcr_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   fwcr_pkg::item_type  entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: design/fwcr_back.sv
// back end: walks the window mask of one pixel and drives one response per hit
// depends on fwcr_pkg
`default_nettype none

module fwcr_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           q_valid,
   input  wire fwcr_pkg::item_type             q_item,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [fwcr_pkg::IDX_BITS-1:0]       rsp_index,
   output logic [fwcr_pkg::CROP_BITS-1:0]      rsp_row,
   output logic [fwcr_pkg::CROP_BITS-1:0]      rsp_col,
   output logic [fwcr_pkg::PIXEL_BITS-1:0]     rsp_pixel,
   output logic                                rsp_last
);

   logic                            work_valid_ff, work_valid_in;
   logic [fwcr_pkg::CODE_SLOTS-1:0] work_mask_ff, work_mask_in;
   fwcr_pkg::item_type              work_item_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fwcr_pkg::IDX_BITS-1:0]   rsp_index_ff;
   logic [fwcr_pkg::CROP_BITS-1:0]  rsp_row_ff, rsp_col_ff;
   logic [fwcr_pkg::PIXEL_BITS-1:0] rsp_pixel_ff;
   logic                            rsp_last_ff;

   logic [fwcr_pkg::CODE_SLOTS-1:0] lowest, remain;
   logic [fwcr_pkg::IDX_BITS-1:0]   sel;
   logic                            out_free, emit, done, load;

   always_comb begin
      lowest = work_mask_ff & (~work_mask_ff + 1'b1);
      remain = work_mask_ff & ~lowest;
      sel    = '0;
      for (int k = fwcr_pkg::CODE_SLOTS - 1; k >= 0; k--) begin
         if (work_mask_ff[k]) begin
            sel = fwcr_pkg::IDX_BITS'(k);
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = work_valid_ff && out_free;
   assign done     = emit && (remain == '0);
   assign load     = q_valid && (!work_valid_ff || done);
   assign q_pop    = load;

   always_comb begin
      work_valid_in = work_valid_ff;
      work_mask_in  = work_mask_ff;
      if (load) begin
         work_valid_in = 1'b1;
         work_mask_in  = q_item.mask;
      end else if (done) begin
         work_valid_in = 1'b0;
      end else if (emit) begin
         work_mask_in  = remain;
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_mask_ff <= work_mask_in;
      if (load) begin
         work_item_ff <= q_item;
      end
      if (emit) begin
         rsp_index_ff <= sel;
         rsp_row_ff   <= work_item_ff.row[sel];
         rsp_col_ff   <= work_item_ff.col[sel];
         rsp_pixel_ff <= work_item_ff.pixel;
         rsp_last_ff  <= (remain == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_row   = rsp_row_ff;
   assign rsp_col   = rsp_col_ff;
   assign rsp_pixel = rsp_pixel_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// self-checking bench for five_window_crop_router: directed and random requests,
// a behavioral predictor of the window routing, and a response scoreboard
// depends on fwcr_pkg (register and position codes, reset values) and the rtl

`default_nettype none

module tb;
   import fwcr_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 16;   // pipeline plus queue depth, with margin
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 16;
   localparam int QUIET_PHASE   = 6;    // from here on, no gaps and no stalls

   // register indexes past the last register, writes there must be dropped
   localparam logic [ADDR_BITS-1:0] REG_HOLE_LO = 3'd6;
   localparam logic [ADDR_BITS-1:0] REG_HOLE_HI = 3'd7;

   // codes that switch a window off
   localparam logic [CODE_BITS-1:0] POS_OFF_5 = 3'd5;
   localparam logic [CODE_BITS-1:0] POS_OFF_6 = 3'd6;
   localparam logic [CODE_BITS-1:0] POS_OFF_7 = 3'd7;

   // one routed pixel as it should leave the block
   typedef struct packed {
      logic [IDX_BITS-1:0]   window;
      logic [CROP_BITS-1:0]  row;
      logic [CROP_BITS-1:0]  col;
      logic [PIXEL_BITS-1:0] pixel;
      logic                  last;
   } crop_hit_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [ADDR_BITS-1:0]  csr_addr   = '0;
   logic [CSR_BITS-1:0]   csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [55:0]           rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  rsp_tlast;

   // predictor copy of the registers, at register width
   logic [IMG_BITS-1:0]   img_rows  = RESET_IMAGE_HEIGHT;
   logic [IMG_BITS-1:0]   img_cols  = RESET_IMAGE_WIDTH;
   logic [CROP_BITS-1:0]  win_rows  = RESET_CROP_HEIGHT;
   logic [CROP_BITS-1:0]  win_cols  = RESET_CROP_WIDTH;
   logic [COUNT_BITS-1:0] win_count = RESET_CROP_COUNT;
   logic [CODES_BITS-1:0] win_codes = RESET_POSITION_CODES;

   // predictor copy of the raster position
   int unsigned row_pos = 0;
   int unsigned col_pos = 0;

   crop_hit_type hits_due[$];
   int        error_count  = 0;
   int        cycle_count  = 0;
   bit        idle_enable  = 1'b1;
   bit        stall_enable = 1'b1;

   always #2 clock = ~clock;

   five_window_crop_router DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] pixel_value
      .req_tuser  (req_tuser),   // [0] plane_start
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [11:0] crop_row, [23:12] crop_col, [55:24] pixel_out
      .rsp_tuser  (rsp_tuser),   // [2:0] crop_index
      .rsp_tlast  (rsp_tlast)    // last_of_run
   );

   // ---------------------------------------------------------------- predictor

   // zero size counts as one row or column, oversize saturates
   function automatic int unsigned fit_dim(input logic [IMG_BITS-1:0] size);
      if (size == '0) return 1;
      if (size > MAX_DIM) return MAX_DIM;
      return size;
   endfunction

   // offset of a centered window, rounded down, zero when the crop does not fit
   function automatic int unsigned centering_margin(input int unsigned img,
                                                    input logic [CROP_BITS-1:0] crop);
      if (crop >= img) return 0;
      return (img - crop) / 2;
   endfunction

   // queue one hit per window covering the current pixel, then step the raster
   task automatic route_pixel(input logic [31:0] pix, input logic start);
      int unsigned rows, cols, row_gap, col_gap, windows, top, left, k;
      logic [CODE_BITS-1:0] code;
      bit placed;
      int hits;
      crop_hit_type hit;
      rows    = fit_dim(img_rows);
      cols    = fit_dim(img_cols);
      row_gap = centering_margin(rows, win_rows);
      col_gap = centering_margin(cols, win_cols);
      windows = win_count;
      if (windows > MAX_CROPS_DEFAULT) windows = MAX_CROPS_DEFAULT;
      if (windows > CODE_SLOTS) windows = CODE_SLOTS;
      // plane start snaps back to the origin, a shrunken image wraps stale counters
      if (start) begin
         row_pos = 0;
         col_pos = 0;
      end
      if (row_pos >= rows) row_pos = 0;
      if (col_pos >= cols) col_pos = 0;
      hits = 0;
      for (k = 0; k < windows; k++) begin
         code   = win_codes[CODE_BITS*k +: CODE_BITS];
         placed = 1'b1;
         top    = 0;
         left   = 0;
         case (code)
            POS_CENTER: begin
               top  = row_gap;
               left = col_gap;
            end
            POS_UPPER_LEFT: begin
            end
            POS_UPPER_RIGHT: begin
               left = 2 * col_gap;
            end
            POS_LOWER_LEFT: begin
               top = 2 * row_gap;
            end
            POS_LOWER_RIGHT: begin
               top  = 2 * row_gap;
               left = 2 * col_gap;
            end
            default: begin
               placed = 1'b0;
            end
         endcase
         if (placed && row_pos >= top && row_pos < top + win_rows &&
             col_pos >= left && col_pos < left + win_cols) begin
            hit.window = IDX_BITS'(k);
            hit.row    = CROP_BITS'(row_pos - top);
            hit.col    = CROP_BITS'(col_pos - left);
            hit.pixel  = pix;
            hit.last   = 1'b0;
            hits_due.push_back(hit);
            hits++;
         end
      end
      if (hits > 0) hits_due[hits_due.size() - 1].last = 1'b1;
      col_pos = col_pos + 1;
      if (col_pos >= cols) begin
         col_pos = 0;
         row_pos = row_pos + 1;
         if (row_pos >= rows) row_pos = 0;
      end
   endtask

   // ---------------------------------------------------------------- scoreboard

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t crop result %s: expected %h actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // every accepted response against the oldest predicted hit
   always @(posedge clock) begin
      crop_hit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hits_due.size() == 0) begin
            $display("%0t unexpected crop result: expected none actual window %0d row %0d col %0d",
                     $time, rsp_tuser, rsp_tdata[11:0], rsp_tdata[23:12]);
            error_count++;
         end else begin
            want = hits_due.pop_front();
            check_field("crop_index", want.window, rsp_tuser);
            check_field("crop_row", want.row, rsp_tdata[11:0]);
            check_field("crop_col", want.col, rsp_tdata[23:12]);
            check_field("pixel_out", want.pixel, rsp_tdata[55:24]);
            check_field("last_of_run", want.last, rsp_tlast);
         end
      end
   end

   // response back-pressure: random stall bursts while enabled
   initial begin
      forever begin
         @(posedge clock);
         if (stall_enable && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("five_window_crop_router: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------- drivers

   // one request; valid stays up after acceptance unless the next call idles
   task automatic send_pixel(input logic [31:0] pix, input logic start);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      route_pixel(pix, start);
   endtask

   // stop requests, let every hit come out, then wait out the settle interval for the pipe to clear
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (hits_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ADDR_BITS-1:0] index,
                            input logic [CSR_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         REG_IMAGE_HEIGHT:   img_rows  = value[IMG_BITS-1:0];
         REG_IMAGE_WIDTH:    img_cols  = value[IMG_BITS-1:0];
         REG_CROP_HEIGHT:    win_rows  = value[CROP_BITS-1:0];
         REG_CROP_WIDTH:     win_cols  = value[CROP_BITS-1:0];
         REG_CROP_COUNT:     win_count = value[COUNT_BITS-1:0];
         REG_POSITION_CODES: win_codes = value[CODES_BITS-1:0];
         default: begin
         end
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(input logic [CSR_BITS-1:0] rows, input logic [CSR_BITS-1:0] cols,
                               input logic [CSR_BITS-1:0] crop_rows,
                               input logic [CSR_BITS-1:0] crop_cols,
                               input logic [CSR_BITS-1:0] count,
                               input logic [CSR_BITS-1:0] codes);
      write_reg(REG_IMAGE_HEIGHT, rows);
      write_reg(REG_IMAGE_WIDTH, cols);
      write_reg(REG_CROP_HEIGHT, crop_rows);
      write_reg(REG_CROP_WIDTH, crop_cols);
      write_reg(REG_CROP_COUNT, count);
      write_reg(REG_POSITION_CODES, codes);
   endtask

   // ---------------------------------------------------------------- tests

   // reset geometry: 256 square image, five 224 windows, origin is upper left only
   task automatic test_reset_defaults();
      send_pixel(32'h0000_0000, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b0);
   endtask

   // crop as large as a 2x2 image: every window covers every pixel, five hits each,
   // with a plane start arriving mid plane
   task automatic test_full_overlap();
      wait_until_drained();
      set_geometry(15'd2, 15'd2, 15'd2, 15'd2, CSR_BITS'(CODE_SLOTS), RESET_POSITION_CODES);
      send_pixel(32'hA5A5_5A5A, 1'b1);
      send_pixel(32'h5A5A_A5A5, 1'b0);
      send_pixel(32'hFFFF_0000, 1'b0);
      send_pixel(32'h0000_FFFF, 1'b1);
      send_pixel(32'h8000_0001, 1'b0);
   endtask

   // odd size difference rounds the offset down, disabled codes skip a window,
   // and an oversized count is cut to five
   task automatic test_odd_gap_disabled();
      int n;
      wait_until_drained();
      set_geometry(15'd5, 15'd4, 15'd2, 15'd2, 15'd7,
                   {POS_LOWER_LEFT, POS_OFF_6, POS_LOWER_RIGHT, POS_OFF_7, POS_CENTER});
      for (n = 0; n < 10; n++) begin
         send_pixel($urandom, n == 0);
      end
   endtask

   // no window in use, then a zero-width crop: counters move, nothing comes out
   task automatic test_empty_windows();
      wait_until_drained();
      write_reg(REG_CROP_COUNT, '0);
      send_pixel($urandom, 1'b0);
      send_pixel($urandom, 1'b0);
      wait_until_drained();
      write_reg(REG_CROP_COUNT, CSR_BITS'(CODE_SLOTS));
      write_reg(REG_CROP_WIDTH, '0);
      send_pixel($urandom, 1'b0);
      send_pixel($urandom, 1'b1);
   endtask

   // zero height acts as one row, all-ones width saturates at the maximum,
   // crop at its largest so every window sits at the origin
   task automatic test_size_extremes();
      wait_until_drained();
      set_geometry('0, 15'h7FFF, 15'hFFF, 15'hFFF, CSR_BITS'(CODE_SLOTS),
                   {POS_UPPER_LEFT, POS_LOWER_RIGHT, POS_LOWER_LEFT, POS_UPPER_RIGHT,
                    POS_CENTER});
      send_pixel(32'hFFFF_FFFF, 1'b1);
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'h1234_5678, 1'b0);
   endtask

   // writes past the last register must leave the geometry alone
   task automatic test_unmapped_writes();
      wait_until_drained();
      write_reg(REG_HOLE_LO, '0);
      write_reg(REG_HOLE_HI, '1);
      send_pixel($urandom, 1'b0);
      send_pixel($urandom, 1'b0);
   endtask

   function automatic logic [CSR_BITS-1:0] pick_image_dim();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return CSR_BITS'(MAX_DIM);
         2:       return CSR_BITS'(MAX_DIM + 1);
         3:       return 15'h7FFF;
         default: return CSR_BITS'($urandom_range(2, 7));
      endcase
   endfunction

   function automatic logic [CSR_BITS-1:0] pick_crop_dim(input logic [CSR_BITS-1:0] img);
      int unsigned upper;
      upper = (img >= 2 && img <= 7) ? img : 7;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 15'hFFF;
         2:       return {3'b000, CROP_BITS'(img + 1'b1)};
         default: return CSR_BITS'($urandom_range(1, upper));
      endcase
   endfunction

   // mostly whole raster planes on small images with random pixels, a stray
   // plane start now and then, and a fresh geometry per phase
   task automatic test_random_planes();
      int phase, n, slot;
      int unsigned in_plane, plane_len;
      logic [CSR_BITS-1:0] rows, cols, count;
      logic [CODES_BITS-1:0] codes;
      logic start;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == QUIET_PHASE) begin
            idle_enable  = 1'b0;
            stall_enable = 1'b0;
         end
         wait_until_drained();
         rows  = pick_image_dim();
         cols  = pick_image_dim();
         count = ($urandom_range(0, 5) == 0) ? CSR_BITS'($urandom_range(0, 7)) :
                                               CSR_BITS'(CODE_SLOTS);
         for (slot = 0; slot < CODE_SLOTS; slot++) begin
            codes[CODE_BITS*slot +: CODE_BITS] = ($urandom_range(0, 7) == 0) ?
               CODE_BITS'($urandom_range(POS_OFF_5, POS_OFF_7)) :
               CODE_BITS'($urandom_range(POS_CENTER, POS_LOWER_RIGHT));
         end
         set_geometry(rows, cols, pick_crop_dim(rows), pick_crop_dim(cols), count, codes);
         plane_len = fit_dim(IMG_BITS'(rows)) * fit_dim(IMG_BITS'(cols));
         // sometimes carry on from where the last phase left the raster
         in_plane = ($urandom_range(0, 3) == 0) ? 1 : 0;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            start = (in_plane == 0) || ($urandom_range(0, 15) == 0);
            if (start) in_plane = 0;
            send_pixel($urandom, start);
            in_plane = (in_plane + 1) % plane_len;
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_full_overlap();
      test_odd_gap_disabled();
      test_empty_windows();
      test_size_extremes();
      test_unmapped_writes();
      test_random_planes();
      wait_until_drained();
      if (error_count == 0) begin
         $display("five_window_crop_router: match");
      end else begin
         $display("five_window_crop_router: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
